// ===== rtl/dfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared types for the duplicate-rejecting FIFO queue: operation and status
// codes, sequencer states and the request and result beats.
// ----------------------------------------------------------------------------
package dfq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_READ = 2'd2,
    OP_FIND = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_MISS  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_FETCH,
    S_WRITE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
    op_e         op;
  } req_t;

  typedef struct packed {
    logic [3:0]  position;
    logic [4:0]  count;
    status_e     status;
    logic [31:0] data_out;
  } result_t;

endpackage

// ===== rtl/dfq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_core
// Queue store and sequencer: a circular buffer in a single-port-read memory,
// scanned one entry at a time through one shared equality comparator.
// ----------------------------------------------------------------------------
module dfq_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  dfq_pkg::req_t    req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output dfq_pkg::result_t res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int IW = (CW > 4) ? CW : 4;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dfq_pkg::state_e        state_q, state_d;
  dfq_pkg::op_e           op_q, op_d;
  dfq_pkg::status_e       status_q, status_d;
  logic [DATA_WIDTH-1:0]  word_q, word_d;
  logic [3:0]             idx_q, idx_d;
  logic [AW-1:0]          head_q, head_d;
  logic [CW-1:0]          occ_q, occ_d;
  logic [AW-1:0]          scan_q, scan_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [DATA_WIDTH-1:0]  data_q, data_d;

  logic [DATA_WIDTH-1:0]  mem [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_q;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic                   mem_we;
  logic                   hit;
  logic                   last;
  logic                   idx_ok;

  assign hit     = (rd_q == word_q);
  assign last    = ((SW'(scan_q) + SW'(1)) == SW'(occ_q));
  assign idx_ok  = (IW'(idx_q) < IW'(occ_q));
  assign rd_addr = wrap_add(head_q, (op_q == dfq_pkg::OP_READ) ? AW'(idx_q) : scan_q);
  assign wr_addr = wrap_add(head_q, AW'(occ_q));
  assign mem_we  = (state_q == dfq_pkg::S_WRITE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= word_q;
    end
    if (state_q == dfq_pkg::S_ISSUE) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    status_d    = status_q;
    word_d      = word_q;
    idx_d       = idx_q;
    head_d      = head_q;
    occ_d       = occ_q;
    scan_d      = scan_q;
    pos_d       = pos_q;
    data_d      = data_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      dfq_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d     = req_i.op;
          word_d   = DATA_WIDTH'(req_i.value);
          idx_d    = req_i.index;
          scan_d   = '0;
          pos_d    = '0;
          data_d   = '0;
          status_d = dfq_pkg::ST_OK;
          state_d  = dfq_pkg::S_ISSUE;
        end
      end
      dfq_pkg::S_ISSUE: begin
        state_d = dfq_pkg::S_FETCH;
        case (op_q)
          dfq_pkg::OP_ENQ: begin
            if (occ_q == '0) begin
              state_d = dfq_pkg::S_WRITE;
            end
          end
          dfq_pkg::OP_DEQ: begin
            if (occ_q == '0) begin
              status_d = dfq_pkg::ST_EMPTY;
              state_d  = dfq_pkg::S_RESP;
            end
          end
          dfq_pkg::OP_READ: begin
            if (!idx_ok) begin
              status_d = dfq_pkg::ST_MISS;
              state_d  = dfq_pkg::S_RESP;
            end
          end
          dfq_pkg::OP_FIND: begin
            if (occ_q == '0) begin
              status_d = dfq_pkg::ST_MISS;
              state_d  = dfq_pkg::S_RESP;
            end
          end
          default: state_d = dfq_pkg::S_RESP;
        endcase
      end
      dfq_pkg::S_FETCH: begin
        state_d = dfq_pkg::S_RESP;
        case (op_q)
          dfq_pkg::OP_DEQ: begin
            data_d = rd_q;
            head_d = wrap_add(head_q, AW'(1));
            occ_d  = occ_q - CW'(1);
          end
          dfq_pkg::OP_READ: begin
            data_d = rd_q;
          end
          dfq_pkg::OP_ENQ: begin
            if (hit) begin
              status_d = dfq_pkg::ST_DUP;
            end else if (!last) begin
              scan_d  = scan_q + AW'(1);
              state_d = dfq_pkg::S_ISSUE;
            end else if (occ_q == CW'(DEPTH)) begin
              status_d = dfq_pkg::ST_FULL;
            end else begin
              state_d = dfq_pkg::S_WRITE;
            end
          end
          dfq_pkg::OP_FIND: begin
            if (hit) begin
              pos_d = scan_q;
            end else if (!last) begin
              scan_d  = scan_q + AW'(1);
              state_d = dfq_pkg::S_ISSUE;
            end else begin
              status_d = dfq_pkg::ST_MISS;
            end
          end
          default: state_d = dfq_pkg::S_RESP;
        endcase
      end
      dfq_pkg::S_WRITE: begin
        occ_d   = occ_q + CW'(1);
        state_d = dfq_pkg::S_RESP;
      end
      dfq_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = dfq_pkg::S_IDLE;
        end
      end
      default: state_d = dfq_pkg::S_IDLE;
    endcase
  end

  assign res_o.data_out = 32'(data_q);
  assign res_o.status   = status_q;
  assign res_o.count    = 5'(occ_q);
  assign res_o.position = 4'(pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfq_pkg::S_IDLE;
      head_q  <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    word_q   <= word_d;
    idx_q    <= idx_d;
    scan_q   <= scan_d;
    pos_q    <= pos_d;
    data_q   <= data_d;
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(DEPTH))
    else $error("occupancy above capacity");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dfq_pkg::S_WRITE |-> occ_q < CW'(DEPTH))
    else $error("write into a full queue");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfq_pkg::S_FETCH && op_q == dfq_pkg::OP_READ) |-> idx_ok)
    else $error("read fetched beyond occupancy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfq_pkg::S_RESP && status_q == dfq_pkg::ST_FULL) |-> occ_q == CW'(DEPTH))
    else $error("full reported below capacity");

  a_deq_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfq_pkg::S_FETCH && op_q == dfq_pkg::OP_DEQ)
      |=> occ_q == $past(occ_q) - CW'(1))
    else $error("dequeue did not release an entry");

endmodule

// ===== rtl/dedup_fifo_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_fifo_queue_top
// FIFO queue that rejects duplicate words, with enqueue, dequeue, indexed
// read and find operations over stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one operation per beat; master channel
//   m_axis returns exactly one result beat per operation, in order.
//   Entries sit in a circular buffer memory; head moves on dequeue, so no
//   data is shifted. One equality comparator checks one held entry at a
//   time: a memory read in the issue state, then a compare in fetch.
//   Steps per operation, accepting edge to output register load:
//     dequeue or read  : issue, fetch, result
//     enqueue          : issue and fetch per entry scanned, then a write if
//                        no duplicate and room (write at once if empty), result
//     find             : issue and fetch per entry until a hit, up to the occupancy, result
//     empty/miss early : issue, result
//   Throughput is set by the scan loop through the single memory read port;
//   the next beat is taken on the edge after the load, even while a result
//   still waits at m_axis.
//   Reset empties the queue at once; no clearing pass is needed.
//   If the receiver stalls, the result holds in the output register and the
//   sequencer waits in its result state after finishing the next operation.
// ----------------------------------------------------------------------------
module dedup_fifo_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // op[1:0], value[33:2], index[37:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // data_out[31:0], status[34:32],
                                     // count[39:35], position[43:40]
);

  dfq_pkg::req_t    req;
  dfq_pkg::result_t res;
  dfq_pkg::result_t out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             res_valid;
  logic             res_ready;

  assign req.op    = dfq_pkg::op_e'(s_axis_tdata[1:0]);
  assign req.value = s_axis_tdata[33:2];
  assign req.index = s_axis_tdata[37:34];

  dfq_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.position, out_q.count, out_q.status, out_q.data_out};

endmodule
